FILE: sv/hmtc_pkg.sv
// ----------------------------------------------------------------------------
// HMP to MIDI track converter package
// Shared constants, result status codes and the job record that the parser
// hands to the byte serializer.
// ----------------------------------------------------------------------------
package hmtc_pkg;

  localparam int COUNT_BITS      = 24;
  localparam int OUT_CNT_BITS    = 24;
  localparam int MAX_DELTA_BYTES = 4;
  localparam int JOB_BYTES       = MAX_DELTA_BYTES;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] END_OF_TRACK = 8'h2F;
  localparam logic [3:0] SYS_NIBBLE   = 4'hF;
  localparam logic [3:0] PGM_NIBBLE   = 4'hC;
  localparam logic [3:0] PRESS_NIBBLE = 4'hD;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_DELTA_LONG = 3'd1,
    ST_NO_STATUS  = 3'd2,
    ST_BAD_STATUS = 3'd3,
    ST_TRUNC      = 3'd4
  } status_e;

  typedef struct packed {
    logic                      clr;
    logic [1:0]                last_idx;
    status_e                   status;
    logic                      ended;
    logic [JOB_BYTES-1:0][7:0] bytes;
  } job_t;

endpackage

FILE: sv/hmtc_front.sv
// ----------------------------------------------------------------------------
// HMP track parser
// Tracks the event phase of the HMP stream, reorders delta groups and
// turns each accepted byte into at most one job of up to four MIDI bytes or an error.
// ----------------------------------------------------------------------------
module hmtc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          first_byte_i,
  input  logic          final_byte_i,
  output logic          job_valid_o,
  output hmtc_pkg::job_t job_o
);
  import hmtc_pkg::*;

  typedef enum logic [5:0] {
    PH_DELTA     = 6'b000001,
    PH_STATUS    = 6'b000010,
    PH_META_TYPE = 6'b000100,
    PH_META_LEN  = 6'b001000,
    PH_META_DATA = 6'b010000,
    PH_CHAN_DATA = 6'b100000
  } phase_e;

  phase_e     phase_q, phase_d, ph_c;
  logic [6:0] dgrp_q [3];
  logic [1:0] dcnt_q, dcnt_d, dcnt_c;
  logic [7:0] rstat_q, rstat_d, rstat_c;
  logic [7:0] remain_q, remain_d, remain_c;
  logic [7:0] mkind_q, mkind_d, mkind_c;
  logic       halted_q, halted_d, halt_c;
  logic       clr_pend_q;
  logic       grp_we, push_c, done, ended;
  logic [2:0] nres;
  status_e    err;
  logic [JOB_BYTES-1:0][7:0] bytes;

  always_comb begin
    logic [1:0] k;
    logic [7:0] dec;
    ph_c     = first_byte_i ? PH_DELTA : phase_q;
    dcnt_c   = first_byte_i ? 2'd0 : dcnt_q;
    rstat_c  = first_byte_i ? 8'd0 : rstat_q;
    remain_c = first_byte_i ? 8'd0 : remain_q;
    mkind_c  = first_byte_i ? 8'd0 : mkind_q;
    halt_c   = first_byte_i ? 1'b0 : halted_q;
    phase_d  = ph_c;
    dcnt_d   = dcnt_c;
    rstat_d  = rstat_c;
    remain_d = remain_c;
    mkind_d  = mkind_c;
    halted_d = halt_c;
    grp_we   = 1'b0;
    nres     = 3'd0;
    bytes    = '0;
    err      = ST_BYTE;
    done     = 1'b0;
    ended    = 1'b0;
    k        = 2'd0;
    dec      = 8'd0;
    case (ph_c)
      PH_DELTA: begin
        if (!in_byte_i[7]) begin
          if (dcnt_c == 2'd3) begin
            err = ST_DELTA_LONG;
          end else begin
            grp_we = 1'b1;
            dcnt_d = dcnt_c + 2'd1;
          end
        end else begin
          bytes[0] = {dcnt_c != 2'd0, in_byte_i[6:0]};
          for (int j = 1; j < JOB_BYTES; j++) begin
            if (2'(j) <= dcnt_c) begin
              k = dcnt_c - 2'(j);
              bytes[j] = {k != 2'd0, dgrp_q[k]};
            end
          end
          nres    = {1'b0, dcnt_c} + 3'd1;
          dcnt_d  = 2'd0;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (in_byte_i == META_STATUS) begin
          bytes[0] = in_byte_i;
          nres     = 3'd1;
          phase_d  = PH_META_TYPE;
        end else if (!in_byte_i[7]) begin
          err = ST_NO_STATUS;
        end else if (in_byte_i[7:4] == SYS_NIBBLE) begin
          err = ST_BAD_STATUS;
        end else begin
          if (in_byte_i != rstat_c) begin
            bytes[0] = in_byte_i;
            nres     = 3'd1;
          end
          rstat_d  = in_byte_i;
          remain_d = (in_byte_i[7:4] inside {PGM_NIBBLE, PRESS_NIBBLE}) ? 8'd1 : 8'd2;
          phase_d  = PH_CHAN_DATA;
        end
      end
      PH_META_TYPE: begin
        bytes[0] = in_byte_i;
        nres     = 3'd1;
        mkind_d  = in_byte_i;
        phase_d  = PH_META_LEN;
      end
      PH_META_LEN: begin
        bytes[0] = in_byte_i;
        nres     = 3'd1;
        remain_d = in_byte_i;
        if (in_byte_i == 8'd0) begin
          done    = 1'b1;
          ended   = (mkind_c == END_OF_TRACK);
          phase_d = PH_DELTA;
        end else begin
          phase_d = PH_META_DATA;
        end
      end
      PH_META_DATA, PH_CHAN_DATA: begin
        bytes[0] = in_byte_i;
        nres     = 3'd1;
        dec      = (remain_c != 8'd0) ? remain_c - 8'd1 : 8'd0;
        remain_d = dec;
        if (dec == 8'd0) begin
          done    = 1'b1;
          ended   = (ph_c == PH_META_DATA) && (mkind_c == END_OF_TRACK);
          phase_d = PH_DELTA;
        end
      end
      default: begin
        phase_d = PH_DELTA;
      end
    endcase

    if (err == ST_BYTE && final_byte_i && !done) begin
      err = ST_TRUNC;
    end
    if (err != ST_BYTE) begin
      push_c   = 1'b1;
      halted_d = 1'b1;
    end else begin
      push_c   = (nres != 3'd0);
      halted_d = final_byte_i | ended;
    end

    // hold all state while halted
    if (halt_c) begin
      push_c   = 1'b0;
      grp_we   = 1'b0;
      phase_d  = ph_c;
      dcnt_d   = dcnt_c;
      rstat_d  = rstat_c;
      remain_d = remain_c;
      mkind_d  = mkind_c;
      halted_d = halt_c;
    end
  end

  assign job_valid_o    = valid_i & push_c;
  assign job_o.clr      = first_byte_i | clr_pend_q;
  assign job_o.last_idx = (err != ST_BYTE) ? 2'd0 : (nres[1:0] - 2'd1);
  assign job_o.status   = err;
  assign job_o.ended    = (err != ST_BYTE) | final_byte_i | ended;
  assign job_o.bytes    = bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      dcnt_q     <= 2'd0;
      rstat_q    <= 8'd0;
      remain_q   <= 8'd0;
      mkind_q    <= 8'd0;
      halted_q   <= 1'b0;
      clr_pend_q <= 1'b0;
    end else if (valid_i) begin
      phase_q    <= phase_d;
      dcnt_q     <= dcnt_d;
      rstat_q    <= rstat_d;
      remain_q   <= remain_d;
      mkind_q    <= mkind_d;
      halted_q   <= halted_d;
      clr_pend_q <= push_c ? 1'b0 : (first_byte_i | clr_pend_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && grp_we) begin
      dgrp_q[dcnt_c] <= in_byte_i[6:0];
    end
  end

endmodule

FILE: sv/hmtc_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer of parsed jobs between parser and
// serializer.
// ----------------------------------------------------------------------------
module hmtc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hmtc_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hmtc_pkg::job_t head_o
);
  import hmtc_pkg::*;

  job_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/hmtc_back.sv
// ----------------------------------------------------------------------------
// MIDI byte serializer
// Walks the bytes of the head job into the output register, one per cycle
// while it is empty or popped, and keeps the saturating per-track byte count.
// ----------------------------------------------------------------------------
module hmtc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     avail_i,
  input  hmtc_pkg::job_t           head_i,
  output logic                     take_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output logic [7:0]               out_byte_o,
  output logic [2:0]               status_o,
  output logic                     last_of_run_o,
  output logic                     track_end_o,
  output logic [hmtc_pkg::OUT_CNT_BITS-1:0] bytes_out_o
);
  import hmtc_pkg::*;

  logic [1:0]            idx_q;
  logic [COUNT_BITS-1:0] cnt_q, base, inc;
  logic                  vld_q, load, is_err, is_last;
  logic [7:0]            byte_q;
  status_e               status_q;
  logic                  last_q, end_q;
  logic [OUT_CNT_BITS-1:0] bytes_q;

  assign load    = avail_i & (~vld_q | pop_i);
  assign base    = (idx_q == 2'd0 && head_i.clr) ? '0 : cnt_q;
  assign inc     = (&base) ? base : base + 1'b1;
  assign is_err  = (head_i.status != ST_BYTE);
  assign is_last = is_err | (idx_q == head_i.last_idx);
  assign take_o  = load & is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
        cnt_q <= is_err ? base : inc;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= is_err ? 8'd0 : head_i.bytes[idx_q];
      status_q <= head_i.status;
      last_q   <= is_last;
      end_q    <= is_last & head_i.ended;
      bytes_q  <= OUT_CNT_BITS'(is_err ? base : inc);
    end
  end

  assign empty_o       = ~vld_q;
  assign out_byte_o    = byte_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;
  assign track_end_o   = end_q;
  assign bytes_out_o   = bytes_q;

endmodule

FILE: sv/hmp_to_midi_track_converter.sv
// ----------------------------------------------------------------------------
// HMP to MIDI track converter
// Converts a stream of HMP track bytes into standard MIDI track bytes.
// ----------------------------------------------------------------------------
// Input side: a queue write port. Present one HMP byte on in_byte_i with
// first_byte_i on the first byte of a track and final_byte_i on the last;
// the byte is taken on a clock edge with push high and full low.
// Output side: a queue read port. While empty is low the oldest result sits
// on out_byte_o, status_o, last_of_run_o, track_end_o and bytes_out_o; it is
// taken on an edge with pop high. A result holds while pop stays low.
// Each input byte yields zero to four results; a delta terminator releases
// up to four bytes, every other byte at most one.
// Each result is registered in the job queue and then in the output register.
// Throughput: one input byte per cycle while full is low, one result per
// cycle while pop is high; the serializer emits one byte a cycle from a
// four-entry job queue; delta bursts fill it and raise full until it drains.
// After a result with track_end set, input bytes produce nothing until a
// byte with first_byte_i set starts the next track.
// Reset clears the parser, the job queue and the output valid flag; the
// block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module hmp_to_midi_track_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o,
  output logic        track_end_o,
  output logic [23:0] bytes_out_o
);
  import hmtc_pkg::*;

  logic fire, job_valid, q_empty, take;
  job_t job, head;

  assign fire = push & ~full;

  hmtc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fire),
    .in_byte_i    (in_byte_i),
    .first_byte_i (first_byte_i),
    .final_byte_i (final_byte_i),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  hmtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (take),
    .empty_o (q_empty),
    .head_o  (head)
  );

  hmtc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (~q_empty),
    .head_i        (head),
    .take_o        (take),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o),
    .track_end_o   (track_end_o),
    .bytes_out_o   (bytes_out_o)
  );

endmodule

FILE: sv/hmtc_checker.sv
// ----------------------------------------------------------------------------
// HMP to MIDI track converter checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hmtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pop,
  input logic        empty,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  status_o,
  input logic        last_of_run_o,
  input logic        track_end_o,
  input logic [23:0] bytes_out_o
);
  import hmtc_pkg::*;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_BYTE) |-> (out_byte_o == 8'd0 && last_of_run_o && track_end_o))
    else $error("error result without zero byte, run end and track end");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && track_end_o) |-> last_of_run_o)
    else $error("track end on a result that does not close its run");

  a_cnt_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_BYTE) |-> (bytes_out_o != 24'd0))
    else $error("emitted byte with zero running count");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(bytes_out_o)))
    else $error("stalled result changed");

endmodule

bind hmp_to_midi_track_converter hmtc_checker u_hmtc_checker (.*);
